### rtl/pcm_pkg.sv
// shared constants and types for the point cluster merge unit
// table geometry, field widths and the layout of one table entry
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pcm_pkg;

  // cluster table geometry
  localparam int MaxClusters = 64;
  localparam int IdxW        = (MaxClusters > 1) ? $clog2(MaxClusters) : 1;
  localparam int CntW        = $clog2(MaxClusters + 1);

  // field widths
  localparam int CoordW    = 32;
  localparam int HitW      = 16;
  localparam int DistW     = 31;
  localparam int OutIdxW   = 6;
  localparam int NumAxes   = 3;
  localparam int ThrW      = 2 * DistW;
  localparam int SqW       = 2 * CoordW;
  localparam int SumW      = SqW + 2;
  localparam int DivCntW   = $clog2(CoordW);

  localparam logic [HitW-1:0]  HitMax         = {HitW{1'b1}};
  localparam logic [DistW-1:0] MatchDistReset = DistW'(98304);

  // register word index of match_distance
  localparam logic RegMatchDist = 1'b0;

  // one table entry: hit count over the three mean coordinates
  typedef struct packed {
    logic [HitW-1:0]                 hits;
    logic [NumAxes-1:0][CoordW-1:0]  pos;
  } entry_t;

endpackage

`default_nettype wire

### rtl/point_cluster_merge_unit.sv
// point cluster merge unit: leader clustering with a running mean per cluster
// holds the cluster table in one synchronous memory, uses pcm_pkg
`timescale 1ns / 1ps
`default_nettype none

// Usage
// s_axis carries one point per request: tdata holds point_x, point_y, point_z.
// m_axis returns one result per point: cluster index, the three means and the
// hit count in tdata, and the created and table_full flags in tuser.
// The APB port holds match_distance at address 0, to be written by the user
// only while idle; the unit does not enforce it. A point is taken when the
// unit is idle, also while an earlier result still sits in the output
// register. The table is scanned one entry per cycle from its single read
// port, through the distance pipeline (table read, difference magnitude,
// square, sum), until a match or the end of the clusters in use. A merge adds
// a re-read of the hit entry, the products and a 32-step restoring divider
// per axis (the three axes run side by side). A point that opens a cluster or
// is dropped goes from the search straight to the result. The unit goes back
// to idle once the result is loaded, and only then takes the next request.
// Reset empties the table through the fill count (no clearing pass) and sets
// match_distance to 1.5 m. When the receiver stalls, the finished result waits
// in the output register and the unit holds the table write until it leaves.

module point_cluster_merge_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // point requests: point_x [31:0], point_y [63:32], point_z [95:64]
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,
  // results: cluster_index [5:0], mean_x [37:6], mean_y [69:38],
  // mean_z [101:70], hit_count [117:102], zero fill [119:118]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [119:0]      m_axis_tdata,
  // result flags: created [0], table_full [1]
  output logic [1:0]        m_axis_tuser,
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IdxW    = pcm_pkg::IdxW;
  localparam int CntW    = pcm_pkg::CntW;
  localparam int CoordW  = pcm_pkg::CoordW;
  localparam int HitW    = pcm_pkg::HitW;
  localparam int NumAxes = pcm_pkg::NumAxes;
  localparam int RemW    = HitW + 1;

  typedef enum logic [2:0] {
    StIdle, StSearch, StHitRead, StHitMul, StHitPrep, StDivide, StResult
  } state_e;

  typedef enum logic [1:0] {KindHit, KindCreate, KindDrop} kind_e;

  state_e                      state_q;
  kind_e                       kind_q;
  logic [pcm_pkg::DistW-1:0]   match_dist_q;
  logic [CntW-1:0]             used_q;
  logic [CntW-1:0]             iss_q;
  logic [IdxW-1:0]             hit_idx_q;
  logic [IdxW-1:0]             res_idx_q;
  logic [pcm_pkg::DivCntW-1:0] div_cnt_q;
  logic                        v1_q, v2_q, v3_q, v4_q;
  logic [IdxW-1:0]             idx1_q, idx2_q, idx3_q, idx4_q;

  logic signed [CoordW-1:0]           pt_q   [NumAxes];
  logic [pcm_pkg::ThrW-1:0]           thr_q;
  pcm_pkg::entry_t                    rd_q;
  logic [CoordW-1:0]                  dmag_q [NumAxes];
  logic [pcm_pkg::SqW-1:0]            sq_q   [NumAxes];
  logic [pcm_pkg::SumW-1:0]           sum_q;
  logic signed [CoordW+HitW:0]        prod_q [NumAxes];
  logic [HitW-1:0]                    hits_q;
  logic [RemW-1:0]                    total_q;
  logic [RemW-1:0]                    rem_q  [NumAxes];
  logic [CoordW-1:0]                  quo_q  [NumAxes];
  logic                               neg_q  [NumAxes];

  pcm_pkg::entry_t mem_q [pcm_pkg::MaxClusters];

  logic              in_acc;
  logic              out_free;
  logic              cfg_wr;
  logic              in_search;
  logic              issue;
  logic              match;
  logic              search_empty;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_en;
  pcm_pkg::entry_t   wr_data;
  logic [RemW-1:0]   rem_d  [NumAxes];
  logic [CoordW-1:0] quo_d  [NumAxes];
  logic [CoordW-1:0] res_mean [NumAxes];
  logic [HitW-1:0]   res_hits;

  // magnitude of the exact difference of two coordinates
  function automatic logic [CoordW-1:0] abs_diff(logic signed [CoordW-1:0] a,
                                                 logic signed [CoordW-1:0] b);
    logic signed [CoordW:0] d;
    logic [CoordW:0]        m;
    d = $signed({a[CoordW-1], a}) - $signed({b[CoordW-1], b});
    m = d[CoordW] ? (CoordW+1)'(-d) : (CoordW+1)'(d);
    return m[CoordW-1:0];
  endfunction

  // handshakes
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign cfg_wr        = psel && penable && pwrite && pready && (paddr[2] == pcm_pkg::RegMatchDist);
  assign pready        = 1'b1;
  assign prdata        = 32'(match_dist_q);

  // search control
  assign in_search    = (state_q == StSearch);
  assign match        = in_search && v4_q && (sum_q < pcm_pkg::SumW'(thr_q));
  assign issue        = in_search && (iss_q < used_q) && !match;
  assign search_empty = in_search && !issue && !v1_q && !v2_q && !v3_q && !v4_q;
  assign rd_addr      = (state_q == StHitRead) ? hit_idx_q : iss_q[IdxW-1:0];

  // one restoring divider step per axis
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      logic [RemW:0] r_ext;
      logic [RemW:0] r_sub;
      r_ext    = {rem_q[a], quo_q[a][CoordW-1]};
      r_sub    = r_ext - (RemW+1)'(total_q);
      rem_d[a] = (r_ext >= (RemW+1)'(total_q)) ? r_sub[RemW-1:0] : r_ext[RemW-1:0];
      quo_d[a] = {quo_q[a][CoordW-2:0], (r_ext >= (RemW+1)'(total_q))};
    end
  end

  // result values and table write data
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      res_mean[a] = '0;
    end
    res_hits = '0;
    case (kind_q)
      KindHit: begin
        for (int a = 0; a < NumAxes; a++) begin
          res_mean[a] = neg_q[a] ? (-quo_q[a]) : quo_q[a];
        end
        res_hits = (hits_q == pcm_pkg::HitMax) ? hits_q : hits_q + HitW'(1);
      end
      KindCreate: begin
        for (int a = 0; a < NumAxes; a++) begin
          res_mean[a] = pt_q[a];
        end
        res_hits = HitW'(1);
      end
      default: begin
        res_hits = '0;
      end
    endcase
    for (int a = 0; a < NumAxes; a++) begin
      wr_data.pos[a] = res_mean[a];
    end
    wr_data.hits = res_hits;
  end

  assign wr_en = (state_q == StResult) && out_free && (kind_q != KindDrop);

  // cluster table
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[res_idx_q] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  // state machine and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      kind_q        <= KindDrop;
      match_dist_q  <= pcm_pkg::MatchDistReset;
      used_q        <= '0;
      iss_q         <= '0;
      hit_idx_q     <= '0;
      res_idx_q     <= '0;
      div_cnt_q     <= '0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      v3_q          <= 1'b0;
      v4_q          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        match_dist_q <= pwdata[pcm_pkg::DistW-1:0];
      end
      // result register: load on a finished point, clear once taken
      if ((state_q == StResult) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      v1_q <= issue;
      v2_q <= v1_q && !match;
      v3_q <= v2_q && !match;
      v4_q <= v3_q && !match;
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            iss_q   <= '0;
            state_q <= StSearch;
          end
        end
        StSearch: begin
          if (issue) begin
            iss_q <= iss_q + CntW'(1);
          end
          if (match) begin
            hit_idx_q <= idx4_q;
            res_idx_q <= idx4_q;
            kind_q    <= KindHit;
            state_q   <= StHitRead;
          end else if (search_empty) begin
            res_idx_q <= used_q[IdxW-1:0];
            kind_q    <= (used_q < CntW'(pcm_pkg::MaxClusters)) ? KindCreate : KindDrop;
            state_q   <= StResult;
          end
        end
        StHitRead: state_q <= StHitMul;
        StHitMul:  state_q <= StHitPrep;
        StHitPrep: begin
          div_cnt_q <= '0;
          state_q   <= StDivide;
        end
        StDivide: begin
          div_cnt_q <= div_cnt_q + pcm_pkg::DivCntW'(1);
          if (div_cnt_q == pcm_pkg::DivCntW'(CoordW - 1)) begin
            state_q <= StResult;
          end
        end
        StResult: begin
          if (out_free) begin
            if (kind_q == KindCreate) begin
              used_q <= used_q + CntW'(1);
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    // capture point and squared radius
    if (in_acc) begin
      for (int a = 0; a < NumAxes; a++) begin
        pt_q[a] <= s_axis_tdata[a*CoordW +: CoordW];
      end
      thr_q <= pcm_pkg::ThrW'(match_dist_q) * pcm_pkg::ThrW'(match_dist_q);
    end

    // distance pipeline
    idx1_q <= iss_q[IdxW-1:0];
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    idx4_q <= idx3_q;
    for (int a = 0; a < NumAxes; a++) begin
      dmag_q[a] <= abs_diff(rd_q.pos[a], pt_q[a]);
      sq_q[a]   <= pcm_pkg::SqW'(dmag_q[a]) * pcm_pkg::SqW'(dmag_q[a]);
    end
    sum_q <= pcm_pkg::SumW'(sq_q[0]) + pcm_pkg::SumW'(sq_q[1]) + pcm_pkg::SumW'(sq_q[2]);

    // weighted sums for the running mean
    if (state_q == StHitMul) begin
      for (int a = 0; a < NumAxes; a++) begin
        prod_q[a] <= (CoordW+HitW+1)'($signed(rd_q.pos[a]))
                   * (CoordW+HitW+1)'($signed({1'b0, rd_q.hits}));
      end
      hits_q  <= rd_q.hits;
      total_q <= RemW'(rd_q.hits) + RemW'(1);
    end

    // rounded dividend, split into start remainder and shift bits
    if (state_q == StHitPrep) begin
      for (int a = 0; a < NumAxes; a++) begin
        logic signed [CoordW+HitW+1:0] num;
        logic [CoordW+HitW+1:0]        mag;
        logic [CoordW+HitW+1:0]        dvd;
        num      = (CoordW+HitW+2)'(prod_q[a]) + (CoordW+HitW+2)'(pt_q[a]);
        mag      = num[CoordW+HitW+1] ? (CoordW+HitW+2)'(-num) : (CoordW+HitW+2)'(num);
        dvd      = mag + (CoordW+HitW+2)'(total_q >> 1);
        rem_q[a] <= RemW'(dvd[CoordW+HitW-1:CoordW]);
        quo_q[a] <= dvd[CoordW-1:0];
        neg_q[a] <= num[CoordW+HitW+1];
      end
    end

    // divider iterations
    if (state_q == StDivide) begin
      for (int a = 0; a < NumAxes; a++) begin
        rem_q[a] <= rem_d[a];
        quo_q[a] <= quo_d[a];
      end
    end

    // output payload
    if ((state_q == StResult) && out_free) begin
      m_axis_tdata <= {2'b00, res_hits, res_mean[2], res_mean[1], res_mean[0],
                       (kind_q == KindDrop) ? pcm_pkg::OutIdxW'(0)
                                            : pcm_pkg::OutIdxW'(res_idx_q)};
      m_axis_tuser <= {(kind_q == KindDrop), (kind_q == KindCreate)};
    end
  end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// self-checking bench for point_cluster_merge_unit: a directed table of points,
// then random point streams under several merge radii, with random stalls
// depends on rtl/pcm_pkg.sv and rtl/point_cluster_merge_unit.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int OutIdxW     = pcm_pkg::OutIdxW;
  localparam int CoordW      = pcm_pkg::CoordW;
  localparam int HitW        = pcm_pkg::HitW;
  localparam int DistW       = pcm_pkg::DistW;
  localparam int MaxClusters = pcm_pkg::MaxClusters;

  // one result as it leaves the unit
  typedef struct packed {
    logic [OutIdxW-1:0] slot;
    logic [CoordW-1:0]  mean_x;
    logic [CoordW-1:0]  mean_y;
    logic [CoordW-1:0]  mean_z;
    logic [HitW-1:0]    hits;
    logic               created;
    logic               dropped;
  } merge_result_t;

  // one directed point, with a typed result where it is obvious
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic              typed;
    merge_result_t     want;
  } stim_row_t;

  localparam logic [CoordW-1:0] CoordMin   = 32'h8000_0000;
  localparam logic [CoordW-1:0] CoordMax   = 32'h7FFF_FFFF;
  localparam logic [DistW-1:0]  RadiusMax  = {DistW{1'b1}};
  localparam logic [2:0]        RadiusAddr = {pcm_pkg::RegMatchDist, 2'b00};
  localparam merge_result_t     NoCheck    = '0;
  localparam int                NumSeeds   = 19;
  localparam int                RingDepth  = 16;

  // directed points, walked in order from reset with the default 1.5 m radius
  localparam stim_row_t SeedRows [NumSeeds] = '{
    // first point opens slot 0
    '{32'h0, 32'h0, 32'h0, 1'b1,
      '{6'd0, 32'h0, 32'h0, 32'h0, 16'd1, 1'b1, 1'b0}},
    // 1 m away merges, mean halfway
    '{32'h0001_0000, 32'h0, 32'h0, 1'b1,
      '{6'd0, 32'h0000_8000, 32'h0, 32'h0, 16'd2, 1'b0, 1'b0}},
    // most negative corner
    '{CoordMin, CoordMin, CoordMin, 1'b1,
      '{6'd1, CoordMin, CoordMin, CoordMin, 16'd1, 1'b1, 1'b0}},
    // most positive corner, distance sum saturates
    '{CoordMax, CoordMax, CoordMax, 1'b1,
      '{6'd2, CoordMax, CoordMax, CoordMax, 16'd1, 1'b1, 1'b0}},
    // half-step ties at both ends of the range
    '{CoordMax, CoordMax, 32'h7FFF_FFFE, 1'b0, NoCheck},
    '{CoordMin, CoordMin, 32'h8000_0001, 1'b0, NoCheck},
    // radius boundary: exactly on the radius opens a new slot
    '{32'h1000_0000, 32'h0, 32'h0, 1'b1,
      '{6'd3, 32'h1000_0000, 32'h0, 32'h0, 16'd1, 1'b1, 1'b0}},
    '{32'h1001_8000, 32'h0, 32'h0, 1'b1,
      '{6'd4, 32'h1001_8000, 32'h0, 32'h0, 16'd1, 1'b1, 1'b0}},
    // one lsb inside the radius merges
    '{32'h0FFE_8001, 32'h0, 32'h0, 1'b0, NoCheck},
    // negative tie rounds away from zero
    '{32'hFFFF_FFFD, 32'h2000_0000, 32'h0, 1'b1,
      '{6'd5, 32'hFFFF_FFFD, 32'h2000_0000, 32'h0, 16'd1, 1'b1, 1'b0}},
    '{32'hFFFF_FFFC, 32'h2000_0000, 32'h0, 1'b0, NoCheck},
    // mixed signs on the axes
    '{32'h0000_0005, 32'hD000_0000, 32'h0000_0007, 1'b1,
      '{6'd6, 32'h0000_0005, 32'hD000_0000, 32'h0000_0007, 16'd1, 1'b1, 1'b0}},
    '{32'hFFFF_FFFA, 32'hD000_0003, 32'h0000_0008, 1'b0, NoCheck},
    // alternating bit patterns
    '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 1'b1,
      '{6'd7, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 16'd1, 1'b1, 1'b0}},
    '{32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 1'b1,
      '{6'd8, 32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 16'd1, 1'b1, 1'b0}},
    // repeated origin, fractional means
    '{32'h0, 32'h0, 32'h0, 1'b0, NoCheck},
    '{32'h0, 32'h0, 32'h0, 1'b0, NoCheck},
    // diagonal just inside, then just outside the radius
    '{32'hAAAB_856A, 32'h5554_7A95, 32'hF0F1_CBB0, 1'b0, NoCheck},
    '{32'h5556_33FD, 32'hAAAB_8952, 32'h0F0F_EDB7, 1'b0, NoCheck}
  };

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  // point_x [31:0], point_y [63:32], point_z [95:64]
  logic [95:0]   s_axis_tdata;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  // cluster_index [5:0], mean_x [37:6], mean_y [69:38], mean_z [101:70],
  // hit_count [117:102], zero fill [119:118]
  logic [119:0]  m_axis_tdata;
  // created [0], table_full [1]
  logic [1:0]    m_axis_tuser;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  // cluster table as the unit should hold it
  logic signed [CoordW-1:0] mean_x_tab [MaxClusters];
  logic signed [CoordW-1:0] mean_y_tab [MaxClusters];
  logic signed [CoordW-1:0] mean_z_tab [MaxClusters];
  logic [HitW-1:0]          hit_tally  [MaxClusters];
  int                       clusters_held = 0;
  logic [DistW-1:0]         merge_radius  = pcm_pkg::MatchDistReset;

  // pending results in request order, as a ring with running counts
  merge_result_t expected_ring [RingDepth];
  int unsigned   exp_wr = 0;
  int unsigned   exp_rd = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   ready_left = 0;

  point_cluster_merge_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  initial begin
    #25_000_000;
    $display("FAILURE");
    $finish;
  end

  // squared axis gap, exact in 64 bits
  function automatic logic [63:0] axis_sq(logic signed [31:0] a, logic signed [31:0] b);
    longint     d;
    logic [63:0] m;
    d = longint'(a) - longint'(b);
    m = (d < 0) ? 64'(-d) : 64'(d);
    return m * m;
  endfunction

  function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // (mean*n + p)/(n+1), nearest, ties away from zero
  function automatic logic [31:0] blend_mean(logic signed [31:0] mean, int unsigned n,
                                             logic signed [31:0] p);
    longint num;
    longint total;
    longint mag;
    longint q;
    num   = longint'(mean) * longint'(n) + longint'(p);
    total = longint'(n) + 1;
    mag   = (num < 0) ? -num : num;
    q     = (mag + total / 2) / total;
    return 32'((num < 0) ? -q : q);
  endfunction

  // search, merge or append, and the result that follows
  function automatic merge_result_t cluster_merge_predict(logic [31:0] px, logic [31:0] py,
                                                          logic [31:0] pz);
    merge_result_t res;
    logic [63:0]   limit_sq;
    logic [63:0]   dist_sq;
    int unsigned   n;
    res = '0;
    limit_sq = 64'(merge_radius) * 64'(merge_radius);
    for (int k = 0; k < clusters_held; k++) begin
      dist_sq = add_clamped(add_clamped(axis_sq(mean_x_tab[k], px),
                                        axis_sq(mean_y_tab[k], py)),
                            axis_sq(mean_z_tab[k], pz));
      if (dist_sq < limit_sq) begin
        n = hit_tally[k];
        mean_x_tab[k] = blend_mean(mean_x_tab[k], n, px);
        mean_y_tab[k] = blend_mean(mean_y_tab[k], n, py);
        mean_z_tab[k] = blend_mean(mean_z_tab[k], n, pz);
        if (hit_tally[k] != pcm_pkg::HitMax) hit_tally[k] = hit_tally[k] + 1'b1;
        res.slot   = OutIdxW'(k);
        res.mean_x = mean_x_tab[k];
        res.mean_y = mean_y_tab[k];
        res.mean_z = mean_z_tab[k];
        res.hits   = hit_tally[k];
        return res;
      end
    end
    if (clusters_held < MaxClusters) begin
      mean_x_tab[clusters_held] = px;
      mean_y_tab[clusters_held] = py;
      mean_z_tab[clusters_held] = pz;
      hit_tally[clusters_held]  = 1;
      res.slot    = OutIdxW'(clusters_held);
      res.mean_x  = px;
      res.mean_y  = py;
      res.mean_z  = pz;
      res.hits    = 1;
      res.created = 1'b1;
      clusters_held++;
    end else begin
      res.dropped = 1'b1;
    end
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t mismatch %s: expected %h, got %h", $time, what, want, got);
    mismatch_count++;
  endtask

  // result side stalls: mostly short, a few long, some long stall-free runs
  always @(posedge clk_i) begin
    if (ready_left != 0) begin
      ready_left--;
    end else if (m_axis_tready) begin
      m_axis_tready <= 1'b0;
      ready_left = ($urandom_range(99) < 6) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
      ready_left = ($urandom_range(99) < 10) ? $urandom_range(150, 400)
                                             : $urandom_range(0, 12);
    end
  end

  // compare each accepted result with the oldest pending one
  always @(posedge clk_i) begin : result_check
    merge_result_t got;
    merge_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.slot    = m_axis_tdata[5:0];
      got.mean_x  = m_axis_tdata[37:6];
      got.mean_y  = m_axis_tdata[69:38];
      got.mean_z  = m_axis_tdata[101:70];
      got.hits    = m_axis_tdata[117:102];
      got.created = m_axis_tuser[0];
      got.dropped = m_axis_tuser[1];
      if (exp_wr == exp_rd) begin
        flag_mismatch("result with nothing pending, cluster_index", '0, 32'(got.slot));
      end else begin
        want = expected_ring[exp_rd % RingDepth];
        exp_rd++;
        if (got.slot !== want.slot)
          flag_mismatch("cluster_index", 32'(want.slot), 32'(got.slot));
        if (got.mean_x !== want.mean_x) flag_mismatch("mean_x", want.mean_x, got.mean_x);
        if (got.mean_y !== want.mean_y) flag_mismatch("mean_y", want.mean_y, got.mean_y);
        if (got.mean_z !== want.mean_z) flag_mismatch("mean_z", want.mean_z, got.mean_z);
        if (got.hits !== want.hits)
          flag_mismatch("hit_count", 32'(want.hits), 32'(got.hits));
        if (got.created !== want.created)
          flag_mismatch("created", 32'(want.created), 32'(got.created));
        if (got.dropped !== want.dropped)
          flag_mismatch("table_full", 32'(want.dropped), 32'(got.dropped));
      end
    end
  end

  // one point request; tvalid stays high for a following point
  task automatic offer_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic typed,
                             merge_result_t want);
    merge_result_t pred;
    s_axis_tdata  <= {z, y, x};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = cluster_merge_predict(x, y, z);
    expected_ring[exp_wr % RingDepth] = typed ? want : pred;
    exp_wr++;
  endtask

  // sender gap: mostly none or short, a few long
  task automatic sender_pause();
    int unsigned roll;
    int unsigned gap;
    roll = $urandom_range(99);
    if (roll < 55) gap = 0;
    else if (roll < 88) gap = $urandom_range(1, 3);
    else if (roll < 97) gap = $urandom_range(4, 15);
    else gap = $urandom_range(30, 90);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off requests until every pending result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (exp_wr != exp_rd);
  endtask

  // write the radius, then read it back in a second transfer
  task automatic set_merge_radius(logic [DistW-1:0] radius);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RadiusAddr;
    pwdata  <= 32'(radius);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    merge_radius = radius;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== 32'(radius)) flag_mismatch("match_distance readback", 32'(radius), readback);
  endtask

  // mostly points near a known cluster, the rest anywhere in range
  task automatic pick_point(int unsigned noise_pct, output logic [31:0] x,
                            output logic [31:0] y, output logic [31:0] z);
    logic [31:0]        axis [3];
    logic signed [31:0] base [3];
    int unsigned        spread;
    int unsigned        k;
    longint             off;
    if (clusters_held == 0 || $urandom_range(99) < noise_pct) begin
      for (int a = 0; a < 3; a++) begin
        case ($urandom_range(19))
          0: axis[a] = CoordMin;
          1: axis[a] = CoordMax;
          2: axis[a] = '0;
          3: axis[a] = '1;
          default: axis[a] = $urandom;
        endcase
      end
    end else begin
      k = $urandom_range(clusters_held - 1);
      base[0] = mean_x_tab[k];
      base[1] = mean_y_tab[k];
      base[2] = mean_z_tab[k];
      // a few points spread out to the full radius, near the boundary
      spread = ($urandom_range(19) == 0) ? 32'(merge_radius) : 32'(merge_radius >> 1);
      for (int a = 0; a < 3; a++) begin
        off = longint'($urandom_range(0, 2 * spread)) - longint'(spread);
        axis[a] = 32'(longint'(base[a]) + off);
      end
    end
    x = axis[0];
    y = axis[1];
    z = axis[2];
  endtask

  // one random phase under a fixed radius
  task automatic run_phase(logic [DistW-1:0] radius, int count, int unsigned noise_pct,
                           bit with_gaps, bit with_drains);
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    drain_results();
    set_merge_radius(radius);
    for (int i = 0; i < count; i++) begin
      pick_point(noise_pct, px, py, pz);
      offer_point(px, py, pz, 1'b0, NoCheck);
      if (with_drains && (i % 97) == 96) drain_results();
      else if (with_gaps) sender_pause();
    end
  endtask

  // main sequence
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed points at the reset radius
    for (int i = 0; i < NumSeeds; i++) begin
      offer_point(SeedRows[i].x, SeedRows[i].y, SeedRows[i].z, SeedRows[i].typed,
                  SeedRows[i].want);
      sender_pause();
    end

    // merges around the default radius
    run_phase(pcm_pkg::MatchDistReset, 420, 5, 1'b1, 1'b0);
    // zero radius: every point opens a slot until the table fills, then drops
    run_phase('0, 40, 30, 1'b1, 1'b0);
    // widest radius, back to back requests
    run_phase(RadiusMax, 300, 20, 1'b0, 1'b0);
    // random radii
    for (int r = 0; r < 3; r++)
      run_phase(DistW'($urandom_range(1024, 1 << 22)), 150, 15, 1'b1, 1'b0);
    // back to the default, with full drains now and then
    run_phase(pcm_pkg::MatchDistReset, 690, 10, 1'b1, 1'b1);

    drain_results();
    repeat (120) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
